// ===== hw/rtl/fpsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// shared types and constants of the 16.16 square root pipeline
// ----------------------------------------------------------------------------
package fpsqrt_pkg;

    localparam int WORD_W     = 32;     // radicand and working width
    localparam int ROOT_W     = 24;     // result width
    localparam int STEPS_ONE  = 16;     // integer-part steps
    localparam int STEPS_TWO  = 8;      // fraction steps
    localparam int STEPS      = STEPS_ONE + STEPS_TWO;
    localparam int FRAC_SHIFT = 16;     // realignment between the phases

    localparam logic [WORD_W-1:0] FIRST_BIT  = 32'h4000_0000;
    localparam logic [WORD_W-1:0] SECOND_BIT = 32'h0000_4000;

    // remainder and partial root carried from cell to cell
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] root;
    } stage_t;

endpackage

// ===== hw/rtl/fpsqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fpsqrt_cell
// one restoring root-extraction step with its own pipeline register
// ----------------------------------------------------------------------------
module fpsqrt_cell #(
    parameter bit          PHASE_TWO = 1'b0,
    parameter logic [31:0] TRIAL_BIT = 32'h4000_0000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpsqrt_pkg::stage_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fpsqrt_pkg::stage_t   out_data
);

    logic                  valid_reg;
    fpsqrt_pkg::stage_t    data_reg;
    fpsqrt_pkg::stage_t    data_next;
    logic                  take;
    logic [fpsqrt_pkg::WORD_W-1:0] diff;

    generate
        if (PHASE_TWO)
        begin : g_unsigned
            // accept when root + bit does not exceed the remainder
            logic [fpsqrt_pkg::WORD_W-1:0] trial;
            always_comb
            begin
                trial = in_data.root + TRIAL_BIT;
                take  = (trial <= in_data.rem);
                diff  = in_data.rem - trial;
            end
        end
        else
        begin : g_signed
            // accept when both wrapped differences stay non-negative
            logic [fpsqrt_pkg::WORD_W-1:0] d1;
            always_comb
            begin
                d1   = in_data.rem - TRIAL_BIT;
                diff = d1 - in_data.root;
                take = !d1[fpsqrt_pkg::WORD_W-1] && !diff[fpsqrt_pkg::WORD_W-1];
            end
        end
    endgenerate

    always_comb
    begin
        if (take)
        begin
            data_next.rem  = diff;
            data_next.root = (in_data.root >> 1) | TRIAL_BIT;
        end
        else
        begin
            data_next.rem  = in_data.rem;
            data_next.root = in_data.root >> 1;
        end
    end

    // a cell takes a new word when empty or when its word moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/fixed_point_square_root.sv =====
// ----------------------------------------------------------------------------
// fixed_point_square_root
// 16.16 square root by digit-by-digit extraction in a chain of 24 cells
// ----------------------------------------------------------------------------
// each word passes through the cells in order, one cell per step, and waits
// in the last cell's register until the output side takes it
// throughput: one word per cycle while the output is ready; each of the 24
// cells holds one word, and back-pressure ripples back cell by cell, so
// empty cells still fill while the output word waits
// reset: asynchronous active-low rst_n clears every cell's valid flag
// ----------------------------------------------------------------------------
module fixed_point_square_root (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] radicand (signed 16.16)
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [23:0] root (unsigned 8.16)
);

    localparam int N = fpsqrt_pkg::STEPS;

    // element i feeds cell i, element N is the last cell's output
    logic                stage_valid [0:N];
    logic                stage_ready [0:N];
    fpsqrt_pkg::stage_t  stage_data  [0:N];

    // the remainder starts as the raw radicand bits, the root at zero
    assign stage_valid[0]     = s_axis_tvalid;
    assign s_axis_tready      = stage_ready[0];
    assign stage_data[0].rem  = s_axis_tdata;
    assign stage_data[0].root = '0;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            fpsqrt_pkg::stage_t cell_in;

            if (i == fpsqrt_pkg::STEPS_ONE)
            begin : g_realign
                // start of the fraction phase: move root and remainder up by
                // sixteen, wrapping at the word width
                assign cell_in.rem  = stage_data[i].rem  << fpsqrt_pkg::FRAC_SHIFT;
                assign cell_in.root = stage_data[i].root << fpsqrt_pkg::FRAC_SHIFT;
            end
            else
            begin : g_pass
                assign cell_in = stage_data[i];
            end

            if (i < fpsqrt_pkg::STEPS_ONE)
            begin : g_one
                // integer phase: trial bit walks down from bit 30 by two
                fpsqrt_cell #(
                    .PHASE_TWO (1'b0),
                    .TRIAL_BIT (fpsqrt_pkg::FIRST_BIT >> (2 * i))
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (stage_valid[i]),
                    .in_ready  (stage_ready[i]),
                    .in_data   (cell_in),
                    .out_valid (stage_valid[i+1]),
                    .out_ready (stage_ready[i+1]),
                    .out_data  (stage_data[i+1])
                );
            end
            else
            begin : g_two
                // fraction phase: trial bit walks down from bit 14 by two
                fpsqrt_cell #(
                    .PHASE_TWO (1'b1),
                    .TRIAL_BIT (fpsqrt_pkg::SECOND_BIT >>
                                (2 * (i - fpsqrt_pkg::STEPS_ONE)))
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (stage_valid[i]),
                    .in_ready  (stage_ready[i]),
                    .in_data   (cell_in),
                    .out_valid (stage_valid[i+1]),
                    .out_ready (stage_ready[i+1]),
                    .out_data  (stage_data[i+1])
                );
            end
        end
    endgenerate

    // the last cell's register is the output register
    assign m_axis_tvalid  = stage_valid[N];
    assign stage_ready[N] = m_axis_tready;
    assign m_axis_tdata   = stage_data[N].root[fpsqrt_pkg::ROOT_W-1:0];

endmodule

// ===== tb/tb_fixed_point_square_root.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_square_root
// self-checking bench for the 16.16 square root pipeline
// ----------------------------------------------------------------------------
// a short table of edge radicands is fed first, then sixty and about nine
// hundred random words of mixed kinds; each root is checked against the table
// or a local model of the digit-by-digit extraction, both stream sides idle at
// random, and the output side is held off once for a long spell to back the pipeline up
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_point_square_root;

    localparam int RANDOM_WORDS = 900;
    localparam int HOLD_CYCLES  = 200;   // long output stall, well past pipeline depth
    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int REPORT_MAX   = 10;
    localparam int PROBE_COUNT  = 21;

    // one row of the directed table; root is only used when fixed is set
    typedef struct {
        logic [fpsqrt_pkg::WORD_W-1:0] radicand;
        bit                            fixed;
        logic [fpsqrt_pkg::ROOT_W-1:0] root;
    } probe_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;   // [31:0] radicand (signed 16.16)
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;         // [23:0] root (unsigned 8.16)

    // roots owed by the pipeline, oldest first
    logic [fpsqrt_pkg::ROOT_W-1:0] expected_roots [$];
    probe_t            probes [PROBE_COUNT];
    int                mismatches    = 0;
    int                idle_cycles   = 0;
    bit                sender_steady = 1'b0; // no gaps on the input side
    bit                hold_output   = 1'b0; // asks the receiver for one long stall

    always #2 clk = ~clk;

    fixed_point_square_root dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // restoring root extraction: integer part on the raw word, then the
    // realigned remainder yields eight fraction bits; everything wraps at 32
    function automatic logic [fpsqrt_pkg::ROOT_W-1:0] sqrt_16_16_root(
        input logic [fpsqrt_pkg::WORD_W-1:0] radicand);
        logic [fpsqrt_pkg::WORD_W-1:0] rem;
        logic [fpsqrt_pkg::WORD_W-1:0] root;
        logic [fpsqrt_pkg::WORD_W-1:0] trial_bit;
        logic [fpsqrt_pkg::WORD_W-1:0] less_bit;
        logic [fpsqrt_pkg::WORD_W-1:0] less_both;
        logic [fpsqrt_pkg::WORD_W-1:0] trial;
        rem       = radicand;
        root      = '0;
        trial_bit = fpsqrt_pkg::FIRST_BIT;
        for (int i = 0; i < fpsqrt_pkg::STEPS_ONE; i++)
        begin
            less_bit  = rem - trial_bit;
            less_both = less_bit - root;
            // signed test: both differences must stay non-negative
            if (!less_bit[fpsqrt_pkg::WORD_W-1] && !less_both[fpsqrt_pkg::WORD_W-1])
            begin
                rem  = less_both;
                root = (root >> 1) | trial_bit;
            end
            else
                root = root >> 1;
            trial_bit = trial_bit >> 2;
        end
        root      = root << fpsqrt_pkg::FRAC_SHIFT;
        rem       = rem << fpsqrt_pkg::FRAC_SHIFT;
        trial_bit = fpsqrt_pkg::SECOND_BIT;
        for (int i = 0; i < fpsqrt_pkg::STEPS_TWO; i++)
        begin
            trial = root + trial_bit;
            // unsigned test in the fraction phase
            if (trial <= rem)
            begin
                rem  = rem - trial;
                root = (root >> 1) | trial_bit;
            end
            else
                root = root >> 1;
            trial_bit = trial_bit >> 2;
        end
        return root[fpsqrt_pkg::ROOT_W-1:0];
    endfunction

    // mixed radicand kinds so that deep accept/reject patterns occur
    function automatic logic [fpsqrt_pkg::WORD_W-1:0] draw_radicand();
        logic [fpsqrt_pkg::WORD_W-1:0] k;
        case ($urandom_range(0, 9)) inside
            [0:3]:      return $urandom;
            [4:5]:      return $urandom_range(0, 32'h000F_FFFF);
            6:
            begin
                // near an exact integer square, either side of it
                k = $urandom_range(0, 46340);
                return k * k + $urandom_range(0, 2) - 1;
            end
            7:          return {1'b1, 31'($urandom)};
            8:          return 32'h7FFF_0000 | 32'($urandom_range(0, 16'hFFFF));
            default:
            begin
                // whole-number squares in 16.16
                k = $urandom_range(0, 181);
                return (k * k) << 16;
            end
        endcase
    endfunction

    // offer one radicand after a random gap (none while sender_steady) and log what it must produce
    task automatic send_word(input logic [fpsqrt_pkg::WORD_W-1:0] radicand,
                             input bit fixed,
                             input logic [fpsqrt_pkg::ROOT_W-1:0] fixed_root);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= radicand;
        do @(posedge clk); while (!s_axis_tready);
        expected_roots.push_back(fixed ? fixed_root : sqrt_16_16_root(radicand));
    endtask

    // stop offering and wait until every owed root has come out
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    initial
    begin
        // zero, exact squares and powers of four read straight off; the rest
        // are edges of the range and negative words, left to the model
        probes = '{
            '{32'h0000_0000, 1'b1, 24'h00_0000},
            '{32'h0000_0001, 1'b1, 24'h00_0100},
            '{32'h0000_0004, 1'b1, 24'h00_0200},
            '{32'h0001_0000, 1'b1, 24'h01_0000},
            '{32'h0004_0000, 1'b1, 24'h02_0000},
            '{32'h0009_0000, 1'b1, 24'h03_0000},
            '{32'h0100_0000, 1'b1, 24'h10_0000},
            '{32'h4000_0000, 1'b1, 24'h80_0000},
            '{32'h0000_0002, 1'b0, 24'h00_0000},
            '{32'h0000_FFFF, 1'b0, 24'h00_0000},
            '{32'h0002_0000, 1'b0, 24'h00_0000},
            '{32'h3FFF_FFFF, 1'b0, 24'h00_0000},
            '{32'h7FFF_FFFF, 1'b0, 24'h00_0000},
            '{32'h5555_5555, 1'b0, 24'h00_0000},
            '{32'hAAAA_AAAA, 1'b0, 24'h00_0000},
            '{32'h8000_0000, 1'b0, 24'h00_0000},
            '{32'h8000_0001, 1'b0, 24'h00_0000},
            '{32'hBFFF_FFFF, 1'b0, 24'h00_0000},
            '{32'hC000_0000, 1'b0, 24'h00_0000},
            '{32'hFFFF_0000, 1'b0, 24'h00_0000},
            '{32'hFFFF_FFFF, 1'b0, 24'h00_0000}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
            send_word(probes[i].radicand, probes[i].fixed, probes[i].root);

        // sender stops until the pipeline is empty
        wait_for_drain();

        // back-to-back words against a stalled output: the cells fill and
        // tready must drop, then everything drains in order
        hold_output   = 1'b1;
        sender_steady = 1'b1;
        repeat (60) send_word(draw_radicand(), 1'b0, '0);
        wait_for_drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // idle pattern changes in blocks, some blocks run without gaps
            if (n % 60 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            send_word(draw_radicand(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait_for_drain();
        // a stray word after the last expected one would still show up here
        repeat (2 * fpsqrt_pkg::STEPS) @(posedge clk);

        if (mismatches == 0)
            $display("fixed_point_square_root: match");
        else
            $display("fixed_point_square_root: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: random ready gaps, one long hold when asked
    // ------------------------------------------------------------------------
    initial
    begin
        int  hold;
        int  taken;
        bit  receiver_steady;
        taken           = 0;
        receiver_steady = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                receiver_steady = ($urandom_range(0, 3) == 0);
            if (hold_output)
            begin
                hold        = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else
                hold = receiver_steady ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;

            if (expected_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected root word %h at %0t", m_axis_tdata, $realtime);
            end
            else if (m_axis_tdata !== expected_roots[0])
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("root differs at %0t: expected %h, got %h",
                             $realtime, expected_roots[0], m_axis_tdata);
                void'(expected_roots.pop_front());
            end
            else
                void'(expected_roots.pop_front());
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: a stuck handshake on both sides ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fixed_point_square_root: mismatch");
            $finish;
        end
    end

endmodule
